### hw/rtl/plcl_pkg.sv
// Shared constants, field layout, saturation helper and divider interface
// types for the piecewise-linear curve lookup. No dependencies.
`default_nettype none

package plcl_pkg;

	localparam int WORD_W     = 32;
	localparam int FRAC_BITS  = 16;
	localparam int MAX_POINTS = 32;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int SAT_W      = 2 * WORD_W + 2;

	// input word layout, lowest bit first
	localparam int IDX_LSB    = 0;
	localparam int PX_LSB     = IDX_LSB + 5;
	localparam int PY_LSB     = PX_LSB + WORD_W;
	localparam int MOTOR_LSB  = PY_LSB + WORD_W;
	localparam int IN_BITS    = MOTOR_LSB + WORD_W;
	localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = WORD_W;

	localparam logic [CFG_IDX_W-1:0] REG_RACK_GAIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd1;

	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_CONVERT = 1'b1;

	localparam logic [WORD_W-1:0] RACK_GAIN_RST   = 32'h0001_0000;
	localparam logic [CNT_W-1:0]  POINT_COUNT_RST = 6'd2;

	typedef struct packed {
		logic                  start;
		logic [2*WORD_W-1:0]   dividend;
		logic [WORD_W-1:0]     divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] quotient;
	} div_rsp_t;

	// saturate a wide signed value to one signed word
	function automatic logic [WORD_W-1:0] sat_word(input logic signed [SAT_W-1:0] v);
		logic fits;
		fits = (&v[SAT_W-1:WORD_W-1]) || (~|v[SAT_W-1:WORD_W-1]);
		if (fits)
			return v[WORD_W-1:0];
		else if (v[SAT_W-1])
			return {1'b1, {(WORD_W-1){1'b0}}};
		else
			return {1'b0, {(WORD_W-1){1'b1}}};
	endfunction

endpackage

`default_nettype wire

### hw/rtl/plcl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module plcl_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### hw/rtl/plcl_div.sv
// Restoring divider, one quotient bit per cycle, for a quotient known to fit
// one word. Depends on plcl_pkg.
`default_nettype none

module plcl_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire plcl_pkg::div_req_t req,
	output plcl_pkg::div_rsp_t      rsp
);
	import plcl_pkg::*;

	localparam int STEP_W = $clog2(WORD_W);

	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] quo_q;
	logic [WORD_W-1:0] dvs_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [WORD_W:0]   trial;
	logic [WORD_W:0]   diff;
	logic              take;

	assign trial = {rem_q, quo_q[WORD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign take  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (&step_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend high half is below the divisor, so the remainder stays one word
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend[2*WORD_W-1:WORD_W];
			quo_q <= req.dividend[WORD_W-1:0];
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
			quo_q <= {quo_q[WORD_W-2:0], take};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q))
		else $error("divider done without a finished run");
	a_no_restart_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");
	a_step_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q && !req.start |=> $stable(step_q))
		else $error("divider step count moved while idle");

endmodule

`default_nettype wire

### hw/rtl/piecewise_linear_curve_lookup.sv
// Piecewise-linear curve lookup: top level with the sequencer, the shared
// multiplier and the breakpoint store. Depends on plcl_pkg, plcl_ram, plcl_div.
//
//   channel  dir  handshake               payload
//   s_axis   in   tvalid/tready           tdata: point_index, point_x, point_y,
//                                          motor_angle; tuser: kind
//   m_axis   out  tvalid/tready           tdata: wheel_angle; tuser: segment_error
//   cfg      in   cfg_we (no wait)        cfg_index, cfg_wdata
//
// A load word is written to the store when accepted. A convert word runs the
// gain, clamp and scan states, then the segment states, and, unless the chosen
// segment is non-increasing, the multiply and the 32-step divider, before the
// output state; the linear scan of the store (one read per cycle) checks at
// most the breakpoints in use.
// s_axis_tready is high only while the sequencer is idle; a finished result
// waits in the output register and a stalled m_axis holds the sequencer in its
// output state. Reset clears control state and the registers; the store is
// not cleared.
`default_nettype none

module piecewise_linear_curve_lookup (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	// point_index[4:0], point_x[36:5], point_y[68:37], motor_angle[100:69], zero pad
	input  wire logic [plcl_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
	// kind
	input  wire logic                                  s_axis_tuser,
	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	// wheel_angle[31:0]
	output logic [plcl_pkg::OUT_TDATA_W-1:0]           m_axis_tdata,
	// segment_error
	output logic                                       m_axis_tuser,
	input  wire logic                                  cfg_we,
	input  wire logic [plcl_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [plcl_pkg::WORD_W-1:0]           cfg_wdata
);
	import plcl_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_GAIN, ST_CLAMP_LO, ST_CLAMP_HI, ST_SCAN, ST_SEG0, ST_SEG1,
		ST_SEG2, ST_SEG3, ST_MUL, ST_DIVS, ST_DIV, ST_OUT
	} state_t;

	state_t                     state_q;
	logic [WORD_W-1:0]          gain_q;
	logic [CNT_W-1:0]           pcount_q;
	logic [CNT_W-1:0]           n_pts;
	logic [IDX_W-1:0]           last_idx;

	logic signed [WORD_W-1:0]   motor_q;
	logic signed [SAT_W-1:0]    prod_q;
	logic signed [WORD_W-1:0]   rack_q;
	logic signed [WORD_W-1:0]   xlo_q;
	logic [IDX_W-1:0]           chk_q;
	logic [IDX_W-1:0]           seg_q;
	logic signed [WORD_W-1:0]   x0_q;
	logic signed [WORD_W-1:0]   y0_q;
	logic signed [WORD_W:0]     dx_q;
	logic signed [WORD_W:0]     dy_q;
	logic signed [WORD_W:0]     traw_q;
	logic [WORD_W-1:0]          tc_q;
	logic [WORD_W-1:0]          mag_q;
	logic                       neg_q;
	logic [WORD_W-1:0]          res_q;
	logic                       err_q;
	logic                       m_valid_q;
	logic [WORD_W-1:0]          m_data_q;
	logic                       m_err_q;

	logic                       s_acc;
	logic                       ram_we;
	logic [IDX_W-1:0]           ram_raddr;
	logic [2*WORD_W-1:0]        ram_rdata;
	logic signed [WORD_W-1:0]   rd_x;
	logic signed [WORD_W-1:0]   rd_y;
	logic signed [WORD_W:0]     mul_a;
	logic signed [WORD_W:0]     mul_b;
	logic signed [WORD_W-1:0]   lo_clamped;
	logic signed [SAT_W-1:0]    y0_ext;
	logic signed [SAT_W-1:0]    q_ext;
	logic signed [SAT_W-1:0]    sum;
	div_req_t                   div_req;
	div_rsp_t                   div_rsp;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= RACK_GAIN_RST;
			pcount_q <= POINT_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RACK_GAIN:   gain_q   <= cfg_wdata;
				REG_POINT_COUNT: pcount_q <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (pcount_q < CNT_W'(2))
			n_pts = CNT_W'(2);
		else if (pcount_q > CNT_W'(MAX_POINTS))
			n_pts = CNT_W'(MAX_POINTS);
		else
			n_pts = pcount_q;
	end
	assign last_idx = IDX_W'(n_pts - 1'b1);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign ram_we        = s_acc && (s_axis_tuser == KIND_LOAD);

	plcl_ram #(
		.WIDTH(2 * WORD_W),
		.DEPTH(MAX_POINTS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(s_axis_tdata[IDX_LSB +: IDX_W]),
		.wdata({s_axis_tdata[PY_LSB +: WORD_W], s_axis_tdata[PX_LSB +: WORD_W]}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_x = ram_rdata[WORD_W-1:0];
	assign rd_y = ram_rdata[2*WORD_W-1:WORD_W];

	// read data arrives in the cycle after the address
	always_comb begin
		unique case (state_q)
			ST_CLAMP_LO: ram_raddr = last_idx;
			ST_SCAN:     ram_raddr = IDX_W'(chk_q + 1'b1);
			ST_SEG0:     ram_raddr = seg_q;
			ST_SEG1:     ram_raddr = IDX_W'(seg_q + 1'b1);
			default:     ram_raddr = '0;
		endcase
	end

	// shared multiplier: signed gain product, then unsigned |dy| * t
	always_comb begin
		if (state_q == ST_GAIN) begin
			mul_a = {motor_q[WORD_W-1], motor_q};
			mul_b = {gain_q[WORD_W-1], gain_q};
		end else begin
			mul_a = {1'b0, mag_q};
			mul_b = {1'b0, tc_q};
		end
	end

	assign lo_clamped = (rack_q < xlo_q) ? xlo_q : rack_q;

	assign div_req.start    = (state_q == ST_DIVS);
	assign div_req.dividend = prod_q[2*WORD_W-1:0];
	assign div_req.divisor  = dx_q[WORD_W-1:0];

	plcl_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	assign y0_ext = {{(SAT_W-WORD_W){y0_q[WORD_W-1]}}, y0_q};
	assign q_ext  = {{(SAT_W-WORD_W){1'b0}}, div_rsp.quotient};
	assign sum    = neg_q ? (y0_ext - q_ext) : (y0_ext + q_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
			chk_q     <= '0;
			seg_q     <= '0;
			motor_q   <= '0;
			prod_q    <= '0;
			rack_q    <= '0;
			xlo_q     <= '0;
			x0_q      <= '0;
			y0_q      <= '0;
			dx_q      <= '0;
			dy_q      <= '0;
			traw_q    <= '0;
			tc_q      <= '0;
			mag_q     <= '0;
			neg_q     <= 1'b0;
			res_q     <= '0;
			err_q     <= 1'b0;
			m_data_q  <= '0;
			m_err_q   <= 1'b0;
		end else begin
			// the output state reloads the word itself
			if (m_axis_tready && state_q != ST_OUT)
				m_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc && s_axis_tuser == KIND_CONVERT) begin
						motor_q <= s_axis_tdata[MOTOR_LSB +: WORD_W];
						state_q <= ST_GAIN;
					end
				end
				ST_GAIN: begin
					prod_q  <= SAT_W'(mul_a) * SAT_W'(mul_b);
					state_q <= ST_CLAMP_LO;
				end
				ST_CLAMP_LO: begin
					rack_q  <= sat_word(prod_q >>> FRAC_BITS);
					xlo_q   <= rd_x;
					state_q <= ST_CLAMP_HI;
				end
				ST_CLAMP_HI: begin
					rack_q  <= (lo_clamped > rd_x) ? rd_x : lo_clamped;
					chk_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					// first breakpoint at or above the value, else the last one
					if (rd_x >= rack_q || chk_q == last_idx) begin
						seg_q   <= (chk_q == '0) ? '0 : IDX_W'(chk_q - 1'b1);
						state_q <= ST_SEG0;
					end else begin
						chk_q <= IDX_W'(chk_q + 1'b1);
					end
				end
				ST_SEG0: state_q <= ST_SEG1;
				ST_SEG1: begin
					x0_q    <= rd_x;
					y0_q    <= rd_y;
					state_q <= ST_SEG2;
				end
				ST_SEG2: begin
					dx_q    <= {rd_x[WORD_W-1], rd_x} - {x0_q[WORD_W-1], x0_q};
					dy_q    <= {rd_y[WORD_W-1], rd_y} - {y0_q[WORD_W-1], y0_q};
					traw_q  <= {rack_q[WORD_W-1], rack_q} - {x0_q[WORD_W-1], x0_q};
					state_q <= ST_SEG3;
				end
				ST_SEG3: begin
					if (dx_q[WORD_W] || dx_q == '0) begin
						res_q   <= y0_q;
						err_q   <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						if (traw_q[WORD_W])
							tc_q <= '0;
						else if (traw_q > dx_q)
							tc_q <= dx_q[WORD_W-1:0];
						else
							tc_q <= traw_q[WORD_W-1:0];
						mag_q   <= dy_q[WORD_W] ? WORD_W'(-dy_q) : dy_q[WORD_W-1:0];
						neg_q   <= dy_q[WORD_W];
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= SAT_W'(mul_a) * SAT_W'(mul_b);
					state_q <= ST_DIVS;
				end
				ST_DIVS: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_rsp.done) begin
						res_q   <= sat_word(sum);
						err_q   <= 1'b0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= res_q;
						m_err_q   <= err_q;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_err_q;

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("divider finished outside the wait state");
	a_word_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q) == ST_OUT)
		else $error("result word raised outside the output state");
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> chk_q <= last_idx)
		else $error("scan ran past the last breakpoint in use");
	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !m_axis_tready |=> m_valid_q && $stable(m_data_q))
		else $error("pending result word lost");

endmodule

`default_nettype wire
